/* rtl/core/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Result kinds, the decoded op handed from front to back, and the byte maps.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned OpFifoDepthDefault = 4;
  localparam int unsigned OutLenW = 16;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChU         = 8'h75;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_UNTERM = 2'd2,
    KIND_BADHEX = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  // an op holds the one or two results of one accepted word that gives any
  typedef struct packed {
    logic    dual;
    result_t res0;
    result_t res1;
  } op_t;

  // escape character -> byte; unknown escapes give a backslash
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h22:   r = 8'h22;
      8'h2f:   r = 8'h2f;
      8'h5c:   r = 8'h5c;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0c;
      8'h6e:   r = 8'h0a;
      8'h72:   r = 8'h0d;
      8'h74:   r = 8'h09;
      default: r = ChBackslash;
    endcase
    return r;
  endfunction

  // hex digit value; bit 4 set flags a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jsu_if.sv */
// ----------------------------------------------------------------------------
// jsu_if: valid/ready channel interfaces of the JSON string unescaper
// One interface for input words and one for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] length;
  logic        last;

  modport source (output valid, output kind, output out_byte, output length,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input length,
                  input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Accepts input words, tracks text/escape/\u mode and pushes decoded ops.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  jsu_in_if.sink         in_i,
  output logic           push_o,
  output jsu_pkg::op_t   op_o,
  input  wire            full_i
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [1:0] hex_cnt_q, hex_cnt_d;
  logic [7:0] hex_acc_q, hex_acc_d;

  logic       take;
  logic       has_res;
  logic [4:0] hv;
  logic [7:0] c;
  logic [7:0] acc_new;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign c          = in_i.in_byte;
  assign hv         = hex_value(c);
  assign acc_new    = {hex_acc_q[3:0], hv[3:0]};

  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    hex_acc_d = hex_acc_q;
    has_res   = 1'b0;
    op_o      = '{dual: 1'b0,
                  res0: '{kind: KIND_DATA, data: 8'h00},
                  res1: '{kind: KIND_DATA, data: 8'h00}};
    if (in_i.end_of_input) begin
      has_res = 1'b1;
      case (mode_q)
        MODE_HEX: begin
          op_o.dual = 1'b1;
          op_o.res0 = '{kind: KIND_BADHEX, data: 8'h00};
          op_o.res1 = '{kind: KIND_UNTERM, data: 8'h00};
        end
        MODE_ESC: begin
          op_o.dual = 1'b1;
          op_o.res0 = '{kind: KIND_DATA, data: ChBackslash};
          op_o.res1 = '{kind: KIND_UNTERM, data: 8'h00};
        end
        default: begin
          op_o.res0 = '{kind: KIND_UNTERM, data: 8'h00};
        end
      endcase
      mode_d    = MODE_TEXT;
      hex_cnt_d = 2'd0;
      hex_acc_d = 8'h00;
    end else begin
      case (mode_q)
        MODE_ESC: begin
          if (c == ChU) begin
            mode_d    = MODE_HEX;
            hex_cnt_d = 2'd0;
            hex_acc_d = 8'h00;
          end else begin
            has_res   = 1'b1;
            op_o.res0 = '{kind: KIND_DATA, data: escape_map(c)};
            mode_d    = MODE_TEXT;
          end
        end
        MODE_HEX: begin
          if (hv[4]) begin
            // bad digit ends the \u, then the byte is taken as in text mode
            has_res   = 1'b1;
            op_o.res0 = '{kind: KIND_BADHEX, data: 8'h00};
            mode_d    = MODE_TEXT;
            hex_cnt_d = 2'd0;
            if (c == ChBackslash) begin
              mode_d = MODE_ESC;
            end else if (c == ChQuote) begin
              op_o.dual = 1'b1;
              op_o.res1 = '{kind: KIND_CLOSE, data: 8'h00};
              hex_acc_d = 8'h00;
            end else begin
              op_o.dual = 1'b1;
              op_o.res1 = '{kind: KIND_DATA, data: c};
            end
          end else begin
            hex_acc_d = acc_new;
            if (hex_cnt_q[0]) begin
              has_res   = 1'b1;
              op_o.res0 = '{kind: KIND_DATA, data: acc_new};
            end
            if (hex_cnt_q == 2'd3) begin
              hex_cnt_d = 2'd0;
              mode_d    = MODE_TEXT;
            end else begin
              hex_cnt_d = hex_cnt_q + 2'd1;
            end
          end
        end
        default: begin
          if (c == ChBackslash) begin
            mode_d = MODE_ESC;
          end else if (c == ChQuote) begin
            has_res   = 1'b1;
            op_o.res0 = '{kind: KIND_CLOSE, data: 8'h00};
            mode_d    = MODE_TEXT;
            hex_cnt_d = 2'd0;
            hex_acc_d = 8'h00;
          end else begin
            has_res   = 1'b1;
            op_o.res0 = '{kind: KIND_DATA, data: c};
          end
        end
      endcase
    end
  end

  assign push_o = take && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_TEXT;
      hex_cnt_q <= 2'd0;
      hex_acc_q <= 8'h00;
    end else if (take) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      hex_acc_q <= hex_acc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_fifo: op queue between decoder and emitter
// Small register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::OpFifoDepthDefault
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  jsu_pkg::op_t   op_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           empty_o,
  output jsu_pkg::op_t   op_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: result emitter
// Steps through each op's results, keeps the string length, drives the port.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back #(
  parameter int unsigned LengthBits = jsu_pkg::LengthBitsDefault
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            empty_i,
  input  jsu_pkg::op_t   op_i,
  output logic           pop_o,
  jsu_out_if.source      out_o
);
  import jsu_pkg::*;

  localparam int unsigned ExtW = (LengthBits > OutLenW) ? LengthBits : OutLenW;

  logic                  valid_q;
  logic [1:0]            kind_q;
  logic [7:0]            byte_q;
  logic [OutLenW-1:0]    len_q;
  logic                  last_q;
  logic                  idx_q;
  logic [LengthBits-1:0] count_q, count_d, count_inc;
  logic [ExtW-1:0]       count_ext;

  logic    load;
  result_t cur;
  logic    is_last;

  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign cur     = idx_q ? op_i.res1 : op_i.res0;
  assign is_last = idx_q || !op_i.dual;
  assign pop_o   = load && is_last;

  always_comb begin
    count_inc = count_q;
    if (cur.kind == KIND_DATA && count_q != '1) begin
      count_inc = count_q + LengthBits'(1);
    end
    count_ext = ExtW'(count_inc);
    // close and unterminated reset the count for the next string
    count_d = count_inc;
    if (cur.kind == KIND_CLOSE || cur.kind == KIND_UNTERM) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur.kind;
      byte_q <= (cur.kind == KIND_DATA) ? cur.data : 8'h00;
      len_q  <= (count_ext > ExtW'({OutLenW{1'b1}})) ? {OutLenW{1'b1}}
                                                      : count_ext[OutLenW-1:0];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
      count_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= !is_last;
        count_q <= count_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.kind     = kind_q;
  assign out_o.out_byte = byte_q;
  assign out_o.length   = len_q;
  assign out_o.last     = last_q;

endmodule

`default_nettype wire

/* rtl/core/json_string_unescaper_core.sv */
// ----------------------------------------------------------------------------
// json_string_unescaper_core: JSON string body unescaper
// Path: decoder, op queue, output register. Throughput: one input word per
//   cycle while the op queue is not full; results leave at one word per cycle
//   while the sink is ready, so a two-result word holds the emitter for both.
// Reset: async active low; mode, queue, counters and output valid clear.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper_core #(
  parameter int unsigned LengthBits  = jsu_pkg::LengthBitsDefault,
  parameter int unsigned OpFifoDepth = jsu_pkg::OpFifoDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);
  import jsu_pkg::*;

  // Front: decodes each input word against the text/escape/\u mode and
  // turns it into zero, one or two results (an op). Words that give no
  // result (a backslash, the 'u' of \u, odd hex digits) push nothing.
  logic push;
  op_t  push_op;
  logic full;

  // Queue: decouples the decoder from output backpressure and from the
  // second result a two-result op has at the emitter. The decoder stalls
  // only when the queue is full.
  logic pop;
  logic empty;
  op_t  head_op;

  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .op_o   (push_op),
    .full_i (full)
  );

  jsu_fifo #(
    .Depth (OpFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .op_o    (head_op)
  );

  // Back: walks the head op one result per cycle while out ready holds,
  // keeps the saturating byte count (cleared after a close or unterminated
  // result) and holds the result in an output register that reloads when taken.
  jsu_back #(
    .LengthBits (LengthBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .op_i    (head_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
